>>> rtl/core/negacyclic_polynomial_fold_core_macros.svh
// Assertion macros for the negacyclic polynomial fold core.
// Used by the checker file; depends on nothing else.
`ifndef NEGACYCLIC_POLYNOMIAL_FOLD_CORE_MACROS_SVH
`define NEGACYCLIC_POLYNOMIAL_FOLD_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPF_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define NPF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/npf_pkg.sv
// Shared constants and types of the negacyclic polynomial fold core.
// No dependencies; compiled before every other file of the core.
package npf_pkg;

  // Default sizing of the accumulator store.
  localparam int MAX_DEGREE_DEF = 1024;
  localparam int ACC_WIDTH_DEF  = 48;

  // Fixed field widths.
  localparam int DEG_W   = 11;
  localparam int COEFF_W = 32;

  localparam logic [DEG_W-1:0] RING_DEGREE_RESET = 11'd1024;

  // Operation carried by an input word.
  typedef enum logic {
    OP_ACCUMULATE = 1'b0,
    OP_DRAIN      = 1'b1
  } opcode_t;

  // Control of the read-modify-write stage.
  typedef struct packed {
    logic valid;
    logic drain;
    logic neg;
    logic last;
    logic fwd;
  } s1_ctrl_t;

endpackage

>>> rtl/core/npf_cfg_if.sv
// Configuration write channel of the fold core (ring degree only).
// Depends on npf_pkg.
interface npf_cfg_if import npf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DEG_W-1:0] ring_degree;

  modport source (output valid, output ring_degree, input ready);
  modport sink (input valid, input ring_degree, output ready);
endinterface

>>> rtl/core/npf_in_if.sv
// Input channel of the fold core: opcode and one signed coefficient.
// Depends on npf_pkg.
interface npf_in_if import npf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  opcode_t                   opcode;
  logic signed [COEFF_W-1:0] coeff_value;

  modport source (output valid, output opcode, output coeff_value, input ready);
  modport sink (input valid, input opcode, input coeff_value, output ready);
endinterface

>>> rtl/core/npf_out_if.sv
// Result channel of the fold core: reduced coefficient, last and saturation flags.
// Depends on npf_pkg for the default accumulator width.
interface npf_out_if import npf_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] coeff_out;
  logic                        last_out;
  logic                        saturated;

  modport source (output valid, output coeff_out, output last_out, output saturated,
                  input ready);
  modport sink (input valid, input coeff_out, input last_out, input saturated,
                output ready);
endinterface

>>> rtl/core/negacyclic_polynomial_fold_core.sv
// A drain's result word is registered in stage one, then in the result queue.
// Throughput: one word (accumulate or drain) per cycle while in_ready is high; the
// accumulator RAM reads at acceptance and writes in the next cycle, with one-deep
// forwarding. Input stalls only in the clearing pass or if the two-word result
// queue would overflow. Reset: synchronous, active low; then the RAM is cleared one
// entry per cycle, with in_ready low. Configuration writes are taken at all times.
module negacyclic_polynomial_fold_core import npf_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  npf_cfg_if.sink    cfg_ch,
  npf_in_if.sink     in_ch,
  npf_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_DEGREE);
  localparam int CW = (DEG_W > AW + 1) ? DEG_W : AW + 1;
  localparam int MW = ACC_WIDTH + 1;
  localparam int QW = ACC_WIDTH + 2;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_DEGREE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DEGREE - 1);
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic [DEG_W-1:0]          ring_degree_r;
  logic [AW-1:0]             write_pos_r;
  logic [AW-1:0]             read_pos_r;
  logic                      neg_r;
  logic                      draining_r;
  logic                      clearing_r;
  logic [AW-1:0]             clr_addr_r;

  s1_ctrl_t                  s1_r;
  s1_ctrl_t                  s1_nxt;
  logic [AW-1:0]             s1_addr_r;
  logic signed [COEFF_W-1:0] s1_coeff_r;
  logic [MW-1:0]             fwd_data_r;

  logic [CW-1:0]             deg_ext;
  logic [CW-1:0]             n_eff;
  logic                      accept;
  logic                      is_drain;
  logic [AW-1:0]             pos;
  logic                      pos_last;
  logic                      issue;

  logic [MW-1:0]             ram_q;
  logic [MW-1:0]             old_word;
  logic signed [ACC_WIDTH-1:0] old_acc;
  logic                      old_sat;
  logic signed [COEFF_W:0]   delta;
  logic signed [ACC_WIDTH:0] sum;
  logic                      ovf;
  logic signed [ACC_WIDTH-1:0] acc_new;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [MW-1:0]             wr_data;

  logic                      push;
  logic [QW-1:0]             push_data;
  logic [QW-1:0]             pop_data;
  logic [1:0]                q_count;
  logic                      pop;
  logic [2:0]                occ;

  // Configuration register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_degree_r <= RING_DEGREE_RESET;
    end else if (cfg_ch.valid) begin
      ring_degree_r <= cfg_ch.ring_degree;
    end
  end

  // Effective degree: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    deg_ext = CW'(ring_degree_r);
    if (deg_ext == '0) begin
      n_eff = CW'(1);
    end else if (deg_ext > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = deg_ext;
    end
  end

  // Acceptance and address selection.
  assign pop    = out_ch.valid && out_ch.ready;
  assign occ    = {1'b0, q_count} + {2'b00, push} - {2'b00, pop};
  assign in_ch.ready = !clearing_r && (occ < 3'd2);

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_drain = (in_ch.opcode == OP_DRAIN);
  assign pos      = is_drain ? read_pos_r : write_pos_r;
  assign pos_last = ((CW'(pos) + CW'(1)) >= n_eff);
  // Accumulate words that arrive during a drain are dropped.
  assign issue    = accept && (is_drain || !draining_r);

  // Position and phase tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r <= '0;
      read_pos_r  <= '0;
      neg_r       <= 1'b0;
      draining_r  <= 1'b0;
    end else if (issue) begin
      if (is_drain) begin
        if (pos_last) begin
          read_pos_r  <= '0;
          write_pos_r <= '0;
          neg_r       <= 1'b0;
          draining_r  <= 1'b0;
        end else begin
          read_pos_r <= pos + AW'(1);
          draining_r <= 1'b1;
        end
      end else begin
        if (pos_last) begin
          write_pos_r <= '0;
          neg_r       <= ~neg_r;
        end else begin
          write_pos_r <= pos + AW'(1);
        end
      end
    end
  end

  // Post-reset clearing pass over the RAM.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Stage-one control; forward when the entry being read is written this cycle.
  always_comb begin
    s1_nxt.valid = issue;
    s1_nxt.drain = is_drain;
    s1_nxt.neg   = neg_r;
    s1_nxt.last  = pos_last;
    s1_nxt.fwd   = wr_en && (wr_addr == pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r  <= pos;
      s1_coeff_r <= in_ch.coeff_value;
      fwd_data_r <= wr_data;
    end
  end

  npf_ram #(
    .DEPTH (MAX_DEGREE),
    .WIDTH (MW)
  ) u_npf_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (pos),
    .rdata (ram_q)
  );

  // Saturating read-modify-write of one accumulator.
  always_comb begin
    old_word = s1_r.fwd ? fwd_data_r : ram_q;
    old_acc  = old_word[ACC_WIDTH-1:0];
    old_sat  = old_word[ACC_WIDTH];
    delta    = s1_r.neg ? -{s1_coeff_r[COEFF_W-1], s1_coeff_r}
                        :  {s1_coeff_r[COEFF_W-1], s1_coeff_r};
    sum      = {old_acc[ACC_WIDTH-1], old_acc}
             + {{(ACC_WIDTH-COEFF_W){delta[COEFF_W]}}, delta};
    ovf      = (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]);
    if (!ovf) begin
      acc_new = sum[ACC_WIDTH-1:0];
    end else if (sum[ACC_WIDTH]) begin
      acc_new = ACC_MIN;
    end else begin
      acc_new = ACC_MAX;
    end
  end

  // RAM write port: clearing pass, drain clear, or updated accumulator.
  always_comb begin
    wr_en   = clearing_r || s1_r.valid;
    wr_addr = clearing_r ? clr_addr_r : s1_addr_r;
    if (clearing_r || s1_r.drain) begin
      wr_data = '0;
    end else begin
      wr_data = {old_sat | ovf, acc_new};
    end
  end

  // Drained words go to the result queue.
  assign push      = s1_r.valid && s1_r.drain;
  assign push_data = {old_acc, s1_r.last, old_sat};

  npf_out_fifo #(
    .WIDTH (QW)
  ) u_npf_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .pop_data  (pop_data),
    .count     (q_count)
  );

  assign out_ch.coeff_out = pop_data[QW-1:2];
  assign out_ch.last_out  = pop_data[1];
  assign out_ch.saturated = pop_data[0];

endmodule

>>> rtl/core/npf_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// Holds the accumulators and their saturation marks; depends on npf_pkg.
module npf_ram import npf_pkg::*; #(
  parameter int DEPTH = MAX_DEGREE_DEF,
  parameter int WIDTH = ACC_WIDTH_DEF + 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read in one clocked block; a read of the entry being written
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/npf_out_fifo.sv
// Two-word result queue between the read-modify-write stage and the output.
// Depends on npf_pkg.
module npf_out_fifo import npf_pkg::*; #(
  parameter int WIDTH = ACC_WIDTH_DEF + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data,
  output logic [1:0]       count
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             pop;

  assign pop = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage of the queued words.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign count     = count_r;

endmodule

>>> rtl/core/npf_checker.sv
// Port-level checker for the negacyclic polynomial fold core, and its bind.
// Depends on npf_pkg and the assertion macro header.
`include "negacyclic_polynomial_fold_core_macros.svh"

module npf_checker import npf_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input opcode_t              in_opcode,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [ACC_WIDTH-1:0] out_coeff,
  input logic                 out_last,
  input logic                 out_sat
);

  logic [1:0]           pending_r;
  logic                 drain_in;
  logic                 word_out;
  logic                 out_stall;
  logic [ACC_WIDTH+1:0] out_pl;

  assign drain_in  = in_valid && in_ready && (in_opcode == OP_DRAIN);
  assign word_out  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_pl    = {out_coeff, out_last, out_sat};

  // Drains accepted whose result words have not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else begin
      pending_r <= pending_r + {1'b0, drain_in} - {1'b0, word_out};
    end
  end

  // A stalled result word holds its payload.
  `NPF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_pl), "result not held")

  // Every result word belongs to an accepted drain.
  `NPF_ASSERT(a_no_spurious, clk, rst_n, out_valid, pending_r != 2'd0, "result without a drain")

  // No more than two drains are ever in flight.
  `NPF_ASSERT(a_pending_bound, clk, rst_n, 1'b1, pending_r != 2'd3, "too many drains in flight")

  // Reset starts the clearing pass, so no word is taken right after it.
  `NPF_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, !rst_n, !in_ready, "input ready right after reset")

endmodule

bind negacyclic_polynomial_fold_core npf_checker #(
  .ACC_WIDTH (ACC_WIDTH)
) u_npf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_coeff (out_ch.coeff_out),
  .out_last  (out_ch.last_out),
  .out_sat   (out_ch.saturated)
);
